// ===== hdl/mrc_pkg.sv =====
// shared types, constants and the byte-wide crc update for the masked region crc block
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned REGION_TOTAL_DEF = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       masked;
    logic       region_end;
  } mrc_in_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic [1:0]  region_index;
    logic        record_end;
  } mrc_out_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b & BYTE_MASK};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrc_in_stage.sv =====
// input register stage holding one byte transaction for the crc core
`timescale 1ns / 1ps

module mrc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrc_pkg::mrc_in_t in_data,
  output logic            item_valid,
  output mrc_pkg::mrc_in_t item,
  input  logic            item_take
);

  logic             valid_r;
  mrc_pkg::mrc_in_t data_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== hdl/mrc_core.sv =====
// crc accumulator and region counter, one byte per cycle unless a region-end byte waits for a free output slot
`timescale 1ns / 1ps

module mrc_core #(
  parameter int unsigned REGION_TOTAL = mrc_pkg::REGION_TOTAL_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  mrc_pkg::mrc_in_t item,
  output logic             item_take,
  input  logic             slot_free,
  output logic             res_valid,
  output mrc_pkg::mrc_out_t res
);

  localparam int unsigned CNT_W = (REGION_TOTAL > 1) ? $clog2(REGION_TOTAL) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REGION_TOTAL - 1);

  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W+1:0] cnt_ext;
  logic [7:0]       byte_in;
  logic             rec_end;

  assign item_take = item_valid && (!item.region_end || slot_free);
  assign byte_in   = item.masked ? 8'd0 : item.data_byte;
  assign crc_upd   = mrc_pkg::crc_byte(crc_r, byte_in);
  assign rec_end   = (cnt_r == CNT_LAST);
  assign cnt_ext   = {2'b00, cnt_r};

  assign res_valid        = item_take && item.region_end;
  assign res.crc_value    = crc_upd ^ mrc_pkg::CRC_ONES;
  assign res.region_index = cnt_ext[1:0];
  assign res.record_end   = rec_end;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (item_take) begin
      if (item.region_end) begin
        crc_nxt = mrc_pkg::CRC_ONES;
        cnt_nxt = rec_end ? '0 : cnt_r + CNT_W'(1);
      end else begin
        crc_nxt = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrc_pkg::CRC_ONES;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/mrc_out_stage.sv =====
// result register for the region crc transaction
`timescale 1ns / 1ps

module mrc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mrc_pkg::mrc_out_t res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output mrc_pkg::mrc_out_t out_data
);

  logic              valid_r;
  mrc_pkg::mrc_out_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

endmodule

// ===== hdl/masked_region_crc32.sv =====
// top level of the masked region crc-32 digest
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | mrc_in_t: data_byte, masked, region_end
//   out     | output    | out_valid/out_ready | mrc_out_t: crc_value, region_index, record_end
//
// one byte per cycle while results are not stalled; a byte waits in the input register until
// the core takes it, and its crc result, if any, is then registered in the output register.
// the crc update is a single byte-wide xor network between the two registers.
// reset (synchronous, active low) sets the crc to all ones and the region count to zero.
// a stalled result only holds region-end bytes and the bytes behind them; other bytes keep flowing.
`timescale 1ns / 1ps

module masked_region_crc32 #(
  parameter int unsigned REGION_TOTAL = mrc_pkg::REGION_TOTAL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrc_pkg::mrc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mrc_pkg::mrc_out_t out_data
);

  logic              item_valid;
  logic              item_take;
  mrc_pkg::mrc_in_t  item;
  logic              slot_free;
  logic              res_valid;
  mrc_pkg::mrc_out_t res;

  mrc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  mrc_core #(
    .REGION_TOTAL(REGION_TOTAL)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  mrc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
